[rtl/elliptic_integral_agm_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the elliptic integral AGM unit.
// ----------------------------------------------------------------------------
`ifndef ELLIPTIC_INTEGRAL_AGM_UNIT_MACROS_SVH
`define ELLIPTIC_INTEGRAL_AGM_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EIA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eia assertion failed");

// Next-cycle implication, checked outside reset.
`define EIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eia assertion failed");

`endif

[rtl/eia_pkg.sv]
// ----------------------------------------------------------------------------
// eia_pkg
// Constants and helper functions for the elliptic integral AGM unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eia_pkg;

  localparam int WORK_FRAC_BITS = 40;
  localparam int SERIES_TERMS   = 15;

  localparam logic [63:0] ONE_F  = 64'd1 << WORK_FRAC_BITS;
  localparam logic [63:0] PI_62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] PI_F   = PI_62 >> (62 - WORK_FRAC_BITS);
  localparam logic [63:0] CAP_62 = 64'd1 << 62;
  localparam logic [31:0] ANGLE_LIMIT = 32'd1686629713;

  // Alignment of the Q2.30 angle and of the 2^-40 tolerance to the work format.
  localparam int X_SHL   = (WORK_FRAC_BITS >= 30) ? WORK_FRAC_BITS - 30 : 0;
  localparam int X_SHR   = (WORK_FRAC_BITS < 30) ? 30 - WORK_FRAC_BITS : 0;
  localparam int TOL_SHL = (WORK_FRAC_BITS >= 40) ? WORK_FRAC_BITS - 40 : 0;
  localparam int TOL_SHR = (WORK_FRAC_BITS < 40) ? 40 - WORK_FRAC_BITS : 0;

  localparam logic [127:0] K_DIVIDEND = {64'd0, PI_F} << 23;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_KSAT  = 2'd2;

  // Factorial ratio of Taylor term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine.
  function automatic logic [63:0] series_den(input logic is_cos, input logic [3:0] k);
    logic [5:0]  k2;
    logic [5:0]  other;
    logic [11:0] prod;
    k2    = {1'b0, k, 1'b0};
    other = is_cos ? k2 - 6'd1 : k2 + 6'd1;
    prod  = 12'(k2) * 12'(other);
    return 64'(prod);
  endfunction

  function automatic logic [63:0] clamp_unit(input logic [63:0] v);
    if (v[63]) begin
      return 64'd0;
    end
    return (v > ONE_F) ? ONE_F : v;
  endfunction

endpackage

`default_nettype wire

[rtl/eia_channels.sv]
// ----------------------------------------------------------------------------
// eia channels
// Valid/ready channels for the angle input and the integral results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface eia_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface eia_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] k_value;
  logic [30:0] e_value;
  logic [1:0]  status;
  modport source (output valid, output k_value, output e_value, output status, input ready);
  modport sink   (input valid, input k_value, input e_value, input status, output ready);
endinterface

`default_nettype wire

[rtl/eia_mul.sv]
// ----------------------------------------------------------------------------
// eia_mul
// Bit-serial 64 x 64 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eia_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [63:0]  x,
  input  wire logic [63:0]  y,
  output logic              done,
  output logic [127:0]      prod
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] xr;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [64:0] sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, xr} : 65'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        xr   <= x;
        hi   <= 64'd0;
        lo   <= y;
      end else if (busy) begin
        // The multiplier shifts out of lo as the product shifts in from the top.
        hi  <= sum[64:1];
        lo  <= {sum[0], lo[63:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/eia_div.sv]
// ----------------------------------------------------------------------------
// eia_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eia_div (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] dividend,
  input  wire logic [63:0]  den,
  output logic              done,
  output logic [63:0]       quo,
  output logic              ovf
);

  logic         busy;
  logic [6:0]   cnt;
  logic [127:0] dd;
  logic [63:0]  rem;
  logic [64:0]  trial;
  logic         qbit;

  assign trial = {rem, dd[127]};
  assign qbit  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        dd   <= dividend;
        rem  <= 64'd0;
        quo  <= 64'd0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem <= qbit ? 64'(trial - {1'b0, den}) : trial[63:0];
        quo <= {quo[62:0], qbit};
        // A quotient bit lost off the top means the quotient needs saturation.
        ovf <= ovf | quo[63];
        dd  <= {dd[126:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/eia_sqrt.sv]
// ----------------------------------------------------------------------------
// eia_sqrt
// Digit-by-digit integer square root of a 128-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eia_sqrt (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [127:0] rad,
  output logic              done,
  output logic [63:0]       root
);

  logic         busy;
  logic [5:0]   cnt;
  logic [127:0] rr;
  logic [64:0]  rem;
  logic [66:0]  cur;
  logic [66:0]  trial;
  logic         take;

  assign cur   = {rem, rr[127:126]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = (cur >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rr   <= rad;
        rem  <= 65'd0;
        root <= 64'd0;
      end else if (busy) begin
        // The remainder stays at most twice the partial root.
        rem  <= take ? 65'(cur - trial) : cur[64:0];
        root <= {root[62:0], take};
        rr   <= {rr[125:0], 2'b00};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/elliptic_integral_agm_unit.sv]
// ----------------------------------------------------------------------------
// elliptic_integral_agm_unit
// Complete elliptic integrals K and E of a modular angle by the AGM.
// ----------------------------------------------------------------------------
// One angle is processed at a time; the next is accepted once the current one
// has its result staged in the output register. A zero or out-of-range angle
// goes straight from idle to the output state. Otherwise the time is set by
// one shared bit-serial 64-bit multiplier, a 128-step divider and a 64-step
// square root: the sine and cosine series (30 products and 30 divisions),
// then up to MAX_ITERATIONS AGM steps (product, root, square and up to
// WORK_FRAC_BITS single-bit shifts), then the K and E quotients. The
// tolerance may be written only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "elliptic_integral_agm_unit_macros.svh"

module elliptic_integral_agm_unit #(
  parameter int MAX_ITERATIONS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  eia_angle_if.sink        sample,
  eia_result_if.source     result,
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int FB = eia_pkg::WORK_FRAC_BITS;
  localparam logic [6:0]    F7       = 7'(FB);
  localparam logic [IW-1:0] ITER_MAX = IW'(MAX_ITERATIONS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_XSQ     = 4'd1;
  localparam logic [3:0] S_SER_MUL = 4'd2;
  localparam logic [3:0] S_SER_DIV = 4'd3;
  localparam logic [3:0] S_MSQ     = 4'd4;
  localparam logic [3:0] S_AB_MUL  = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_CC_MUL  = 4'd7;
  localparam logic [3:0] S_WSHIFT  = 4'd8;
  localparam logic [3:0] S_KDIV    = 4'd9;
  localparam logic [3:0] S_GMUL    = 4'd10;
  localparam logic [3:0] S_EDIV    = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  logic [3:0]    state;
  logic          go;
  logic [19:0]   tolerance;
  logic [63:0]   tol;
  logic [63:0]   x;
  logic [63:0]   x2;
  logic [63:0]   t;
  logic [63:0]   sn;
  logic [63:0]   cs;
  logic [3:0]    k;
  logic          ser_cos;
  logic [63:0]   a;
  logic [63:0]   b;
  logic [63:0]   c;
  logic [63:0]   s;
  logic [IW-1:0] iter;
  logic [127:0]  wreg;
  logic          wovf;
  logic          wleft;
  logic [6:0]    wcnt;
  logic [31:0]   kq;
  logic          ksat;
  logic [63:0]   g;
  logic [31:0]   pend_k;
  logic [30:0]   pend_e;
  logic [1:0]    pend_st;
  logic          res_valid;
  logic          res_load;

  // Unit hookup.
  logic          mul_start;
  logic [63:0]   mul_x;
  logic [63:0]   mul_y;
  logic          mul_done;
  logic [127:0]  mul_prod;
  logic          div_start;
  logic [127:0]  div_dividend;
  logic [63:0]   div_den;
  logic          div_done;
  logic [63:0]   div_quo;
  logic          div_ovf;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [63:0]   sqrt_root;

  logic [31:0]   mag;
  logic [63:0]   fm;
  logic [63:0]   sn_upd;
  logic [63:0]   cs_upd;
  logic [64:0]   ab_sum;
  logic [63:0]   w_val;
  logic [64:0]   s_sum;
  logic [63:0]   s_new;
  logic [63:0]   s_half;
  logic [63:0]   f_val;
  logic          esat;

  eia_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  eia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .den      (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .ovf      (div_ovf)
  );

  eia_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (mul_prod),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign mag    = sample.angle[31] ? (~sample.angle + 32'd1) : sample.angle;
  assign fm     = mul_prod[FB+63:FB];
  assign sn_upd = k[0] ? sn - div_quo : sn + div_quo;
  assign cs_upd = k[0] ? cs - div_quo : cs + div_quo;
  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign w_val  = (wovf || (wreg[127:64] != 64'd0)) ? eia_pkg::CAP_62 :
                  ((wreg[63:0] > eia_pkg::CAP_62) ? eia_pkg::CAP_62 : wreg[63:0]);
  assign s_sum  = {1'b0, s} + {1'b0, w_val};
  assign s_new  = (s_sum > {1'b0, eia_pkg::CAP_62}) ? eia_pkg::CAP_62 : s_sum[63:0];
  assign s_half = {1'b0, s[63:1]};
  assign f_val  = (s_half >= eia_pkg::ONE_F) ? 64'd0 : eia_pkg::ONE_F - s_half;
  assign esat   = div_ovf | (div_quo[63:31] != 33'd0);

  assign mul_start  = go && (state == S_XSQ || state == S_SER_MUL || state == S_MSQ ||
                             state == S_AB_MUL || state == S_CC_MUL || state == S_GMUL);
  assign div_start  = go && (state == S_SER_DIV || state == S_KDIV || state == S_EDIV);
  assign sqrt_start = go && (state == S_SQRT);

  always_comb begin
    case (state)
      S_XSQ: begin
        mul_x = x;
        mul_y = x;
      end
      S_SER_MUL: begin
        mul_x = t;
        mul_y = x2;
      end
      S_MSQ: begin
        mul_x = sn;
        mul_y = sn;
      end
      S_CC_MUL: begin
        mul_x = c;
        mul_y = c;
      end
      S_GMUL: begin
        mul_x = eia_pkg::PI_F;
        mul_y = f_val;
      end
      default: begin
        mul_x = a;
        mul_y = b;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_SER_DIV: begin
        div_dividend = {64'd0, fm};
        div_den      = eia_pkg::series_den(ser_cos, k);
      end
      S_EDIV: begin
        div_dividend = {34'd0, g, 30'd0};
        div_den      = a;
      end
      default: begin
        div_dividend = eia_pkg::K_DIVIDEND;
        div_den      = a;
      end
    endcase
  end

  assign sample.ready   = (state == S_IDLE);
  assign res_load       = (state == S_OUT) && (!res_valid || result.ready);
  assign result.valid   = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 20'd1;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.k_value <= pend_k;
      result.e_value <= pend_e;
      result.status  <= pend_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
      iter  <= '0;
    end else begin
      go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            tol <= ({44'd0, tolerance} << eia_pkg::TOL_SHL) >> eia_pkg::TOL_SHR;
            if (mag > eia_pkg::ANGLE_LIMIT || mag == 32'd0) begin
              pend_k  <= 32'd0;
              pend_e  <= 31'd0;
              pend_st <= (mag == 32'd0) ? eia_pkg::ST_OK : eia_pkg::ST_RANGE;
              state   <= S_OUT;
            end else begin
              x     <= ({32'd0, mag} << eia_pkg::X_SHL) >> eia_pkg::X_SHR;
              state <= S_XSQ;
              go    <= 1'b1;
            end
          end
        end
        S_XSQ: begin
          if (mul_done) begin
            x2      <= fm;
            sn      <= x;
            t       <= x;
            k       <= 4'd1;
            ser_cos <= 1'b0;
            state   <= S_SER_MUL;
            go      <= 1'b1;
          end
        end
        S_SER_MUL: begin
          if (mul_done) begin
            state <= S_SER_DIV;
            go    <= 1'b1;
          end
        end
        S_SER_DIV: begin
          if (div_done) begin
            go <= 1'b1;
            if (!ser_cos) begin
              sn <= sn_upd;
              if (k == 4'(eia_pkg::SERIES_TERMS)) begin
                ser_cos <= 1'b1;
                k       <= 4'd1;
                t       <= eia_pkg::ONE_F;
                cs      <= eia_pkg::ONE_F;
              end else begin
                k <= k + 4'd1;
                t <= div_quo;
              end
              state <= S_SER_MUL;
            end else if (k == 4'(eia_pkg::SERIES_TERMS)) begin
              sn    <= eia_pkg::clamp_unit(sn);
              cs    <= eia_pkg::clamp_unit(cs_upd);
              state <= S_MSQ;
            end else begin
              cs    <= cs_upd;
              k     <= k + 4'd1;
              t     <= div_quo;
              state <= S_SER_MUL;
            end
          end
        end
        S_MSQ: begin
          if (mul_done) begin
            s     <= fm;
            a     <= eia_pkg::ONE_F;
            b     <= cs;
            iter  <= '0;
            state <= S_AB_MUL;
            go    <= 1'b1;
          end
        end
        S_AB_MUL: begin
          if (mul_done) begin
            // The root unit reads a*b straight from the idle multiplier.
            a     <= ab_sum[64:1];
            c     <= (a >= b) ? {1'b0, a[63:1] - b[63:1] - 63'(~a[0] & b[0])} : 64'd0;
            iter  <= iter + 1'b1;
            state <= S_SQRT;
            go    <= 1'b1;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            b     <= sqrt_root;
            state <= S_CC_MUL;
            go    <= 1'b1;
          end
        end
        S_CC_MUL: begin
          if (mul_done) begin
            wreg <= mul_prod;
            wovf <= 1'b0;
            if (7'(iter) <= F7) begin
              wleft <= 1'b0;
              wcnt  <= F7 - 7'(iter);
            end else begin
              wleft <= 1'b1;
              wcnt  <= 7'(iter) - F7;
            end
            state <= S_WSHIFT;
          end
        end
        S_WSHIFT: begin
          if (wcnt == 7'd0) begin
            s  <= s_new;
            go <= 1'b1;
            if (w_val > tol && iter < ITER_MAX) begin
              state <= S_AB_MUL;
            end else begin
              state <= S_KDIV;
            end
          end else begin
            wcnt <= wcnt - 7'd1;
            if (wleft) begin
              wovf <= wovf | wreg[127];
              wreg <= {wreg[126:0], 1'b0};
            end else begin
              wreg <= {1'b0, wreg[127:1]};
            end
          end
        end
        S_KDIV: begin
          if (div_done) begin
            kq    <= div_quo[31:0];
            ksat  <= div_ovf | (div_quo[63:32] != 32'd0);
            state <= S_GMUL;
            go    <= 1'b1;
          end
        end
        S_GMUL: begin
          if (mul_done) begin
            g     <= {1'b0, fm[63:1]};
            state <= S_EDIV;
            go    <= 1'b1;
          end
        end
        S_EDIV: begin
          if (div_done) begin
            pend_k  <= ksat ? 32'hFFFF_FFFF : kq;
            pend_e  <= esat ? 31'h7FFF_FFFF : div_quo[30:0];
            pend_st <= ksat ? eia_pkg::ST_KSAT : eia_pkg::ST_OK;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EIA_ASSERT_NOW(a_mul_done_state, clk, rst, mul_done, (state == S_XSQ || state == S_SER_MUL || state == S_MSQ || state == S_AB_MUL || state == S_CC_MUL || state == S_GMUL))
  `EIA_ASSERT_NOW(a_div_done_state, clk, rst, div_done, (state == S_SER_DIV || state == S_KDIV || state == S_EDIV))
  `EIA_ASSERT_NOW(a_iter_cap, clk, rst, (state == S_WSHIFT), (iter <= ITER_MAX && iter != '0))
  `EIA_ASSERT_NOW(a_sum_cap, clk, rst, (state == S_AB_MUL || state == S_KDIV), (s <= eia_pkg::CAP_62))
  `EIA_ASSERT_NEXT(a_ksat_code, clk, rst, res_load && (pend_st == eia_pkg::ST_KSAT), (result.k_value == 32'hFFFF_FFFF))

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for elliptic_integral_agm_unit. A clocked driver feeds
// angle transactions from a pending queue. A bit-exact predictor computes the
// expected K, E and status of each accepted angle. A clocked monitor checks
// every result transaction against the oldest expectation. The tolerance is
// rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int LONG_HOLD      = 30000;

  typedef struct packed {
    logic [31:0] k_value;
    logic [30:0] e_value;
    logic [1:0]  status;
  } integrals_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [19:0] cfg_wdata;

  eia_angle_if  angle_ch ();
  eia_result_if result_ch ();

  elliptic_integral_agm_unit dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (angle_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [31:0] pending_angles[$];
  integrals_t  expected_integrals[$];
  logic [19:0] cur_tolerance;
  bit          idle_enabled;
  bit          hold_request;
  int          errors;
  int          angles_sent;
  int          results_seen;
  int          ksat_seen;
  int          range_seen;
  int          phases_run;
  int          send_gap;
  int          recv_gap;
  int          hold_count;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- fixed-point predictor ------------------------------------------------

  function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[103:40];
  endfunction

  function automatic logic [63:0] unit_clip(input logic [63:0] v);
    if (v[63]) begin
      return 64'd0;
    end
    return (v > eia_pkg::ONE_F) ? eia_pkg::ONE_F : v;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = 64'd0;
    for (int bitn = 63; bitn >= 0; bitn--) begin
      t  = r | (64'd1 << bitn);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  // floor(c*c*2^i / 2^40), saturated at 2^62.
  function automatic logic [63:0] scaled_square(input logic [63:0] c, input int i);
    logic [127:0] p;
    logic [127:0] q;
    int           sh;
    p  = {64'd0, c} * {64'd0, c};
    sh = eia_pkg::WORK_FRAC_BITS - i;
    if (sh >= 0) begin
      q = p >> sh;
    end else begin
      if ((p >> (64 + sh)) != 128'd0) begin
        return eia_pkg::CAP_62;
      end
      q = p << (-sh);
    end
    if (q[127:64] != 64'd0) begin
      return eia_pkg::CAP_62;
    end
    return (q[63:0] > eia_pkg::CAP_62) ? eia_pkg::CAP_62 : q[63:0];
  endfunction

  function automatic integrals_t predict_integrals(input logic [31:0] raw,
                                                   input logic [19:0] tol_reg);
    integrals_t   res;
    logic [31:0]  mag;
    logic [63:0]  x, x2, sn, cs, t, m, a, b, s, an, c, w, tol, f, g;
    logic [127:0] prod, kq, eq;
    int           i;
    res = '0;
    mag = raw[31] ? (~raw + 32'd1) : raw;
    if (mag > eia_pkg::ANGLE_LIMIT) begin
      res.status = eia_pkg::ST_RANGE;
      return res;
    end
    if (mag == 32'd0) begin
      res.status = eia_pkg::ST_OK;
      return res;
    end
    x  = {32'd0, mag} << (eia_pkg::WORK_FRAC_BITS - 30);
    x2 = fx_mul(x, x);
    sn = x;
    t  = x;
    for (int k = 1; k <= eia_pkg::SERIES_TERMS; k++) begin
      t  = fx_mul(t, x2) / 64'((2 * k) * (2 * k + 1));
      sn = (k % 2 == 1) ? sn - t : sn + t;
    end
    cs = eia_pkg::ONE_F;
    t  = eia_pkg::ONE_F;
    for (int k = 1; k <= eia_pkg::SERIES_TERMS; k++) begin
      t  = fx_mul(t, x2) / 64'((2 * k - 1) * (2 * k));
      cs = (k % 2 == 1) ? cs - t : cs + t;
    end
    sn  = unit_clip(sn);
    cs  = unit_clip(cs);
    m   = fx_mul(sn, sn);
    tol = {44'd0, tol_reg};
    a   = eia_pkg::ONE_F;
    b   = cs;
    s   = m;
    i   = 0;
    do begin
      an   = (a + b) >> 1;
      prod = {64'd0, a} * {64'd0, b};
      c    = (a >= b) ? ((a - b) >> 1) : 64'd0;
      b    = root_floor(prod);
      a    = an;
      i++;
      w = scaled_square(c, i);
      s = s + w;
      if (s > eia_pkg::CAP_62) begin
        s = eia_pkg::CAP_62;
      end
    end while (w > tol && i < 32);
    if (a == 64'd0) begin
      res.k_value = '1;
      res.e_value = '1;
      res.status  = eia_pkg::ST_KSAT;
      return res;
    end
    kq = ({64'd0, eia_pkg::PI_F} << 23) / {64'd0, a};
    if (kq > 128'hFFFF_FFFF) begin
      res.k_value = '1;
      res.status  = eia_pkg::ST_KSAT;
    end else begin
      res.k_value = kq[31:0];
      res.status  = eia_pkg::ST_OK;
    end
    f  = ((s >> 1) >= eia_pkg::ONE_F) ? 64'd0 : eia_pkg::ONE_F - (s >> 1);
    g  = fx_mul(eia_pkg::PI_F, f) >> 1;
    eq = ({64'd0, g} << 30) / {64'd0, a};
    res.e_value = (eq > 128'h7FFF_FFFF) ? 31'h7FFF_FFFF : eq[30:0];
    return res;
  endfunction

  // ---- driver ---------------------------------------------------------------

  always @(posedge clk) begin
    bit          slot_free;
    logic        nxt_valid;
    logic [31:0] nxt_angle;
    if (rst) begin
      angle_ch.valid <= 1'b0;
      angle_ch.angle <= '0;
      send_gap       <= 0;
    end else begin
      slot_free = !angle_ch.valid || angle_ch.ready;
      nxt_valid = angle_ch.valid;
      nxt_angle = angle_ch.angle;
      if (angle_ch.valid && angle_ch.ready) begin
        expected_integrals.push_back(predict_integrals(angle_ch.angle, cur_tolerance));
        angles_sent++;
      end
      if (slot_free) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_angles.size() > 0) begin
          if (idle_enabled && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(1, 15);
          end else begin
            nxt_valid = 1'b1;
            nxt_angle = pending_angles.pop_front();
          end
        end
      end
      angle_ch.valid <= nxt_valid;
      angle_ch.angle <= nxt_angle;
    end
  end

  // ---- monitor --------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%08h expected 0x%08h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    integrals_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap        <= 0;
      hold_count      <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (result_ch.status == eia_pkg::ST_KSAT) ksat_seen++;
        if (result_ch.status == eia_pkg::ST_RANGE) range_seen++;
        if (expected_integrals.size() == 0) begin
          report_mismatch("unexpected result transaction", result_ch.k_value, 32'd0);
        end else begin
          want = expected_integrals.pop_front();
          if (result_ch.k_value !== want.k_value)
            report_mismatch("k_value", result_ch.k_value, want.k_value);
          if (result_ch.e_value !== want.e_value)
            report_mismatch("e_value", {1'b0, result_ch.e_value}, {1'b0, want.e_value});
          if (result_ch.status !== want.status)
            report_mismatch("status", {30'd0, result_ch.status}, {30'd0, want.status});
        end
      end
      // A long hold lets the sender back up against a full unit.
      if (hold_request && hold_count < LONG_HOLD) begin
        hold_count      <= hold_count + 1;
        result_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap        <= recv_gap - 1;
        result_ch.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
        recv_gap        <= $urandom_range(1, 15);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
      if (!hold_request) begin
        hold_count <= 0;
      end
    end
  end

  // ---- watchdog -------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (angle_ch.valid && angle_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_integrals.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- stimulus -------------------------------------------------------------

  function automatic logic [31:0] random_angle();
    logic [31:0] mag;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      mag = $urandom_range(32'h7FFF_FFFF, eia_pkg::ANGLE_LIMIT + 32'd1);
    end else if (pick < 11) begin
      return 32'd0;
    end else if (pick < 30) begin
      mag = $urandom_range(1 << 20, 1);
    end else begin
      mag = $urandom_range(eia_pkg::ANGLE_LIMIT, 1);
    end
    return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
  endfunction

  task automatic wait_idle();
    while (pending_angles.size() > 0 || angle_ch.valid || expected_integrals.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [19:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    cur_tolerance = value;
    phases_run++;
  endtask

  initial begin
    logic [19:0] tol_plan[8];
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    cur_tolerance = 20'd1;
    idle_enabled  = 1'b1;
    hold_request  = 1'b0;
    errors        = 0;
    angles_sent   = 0;
    results_seen  = 0;
    ksat_seen     = 0;
    range_seen    = 0;
    phases_run    = 0;
    quiet_cycles  = 0;
    angle_ch.valid  = 1'b0;
    angle_ch.angle  = '0;
    result_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, range limits, sign extremes, small and near-quarter-turn angles.
    write_tolerance(20'd1);
    foreach (tol_plan[j]) tol_plan[j] = 20'($urandom_range(20'hFFFFF, 2));
    tol_plan[0] = 20'hFFFFF;
    tol_plan[1] = 20'd0;
    tol_plan[6] = 20'd1;
    pending_angles = '{32'd0, eia_pkg::ANGLE_LIMIT, -eia_pkg::ANGLE_LIMIT,
                       eia_pkg::ANGLE_LIMIT + 32'd1, -(eia_pkg::ANGLE_LIMIT + 32'd1),
                       32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0001, 32'd1, 32'hFFFF_FFFF, 32'd1024, 32'h4000_0000,
                       32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAB,
                       eia_pkg::ANGLE_LIMIT - 32'd1,
                       32'h6000_0000, 32'h2AAA_AAAA};

    for (int ph = 0; ph < 8; ph++) begin
      write_tolerance(tol_plan[ph]);
      if (ph == 7) idle_enabled = 1'b0;
      if (ph == 2) begin
        // Several angles queued behind a receiver that refuses results.
        hold_request = 1'b1;
        repeat (6) pending_angles.push_back(random_angle());
        wait_idle();
        hold_request = 1'b0;
      end
      repeat (142) pending_angles.push_back(random_angle());
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("%0d angles over %0d tolerance settings, %0d results checked",
             angles_sent, phases_run, results_seen);
    $display("%0d out-of-range and %0d saturated-K results seen", range_seen, ksat_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
